// ===== hdl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the class border dilation block
// Code widths, register indexes, register reset values and the neighbor
// flag group handed from the control stage to the window.
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int CBD_MAX_WIDTH = 1024;

	localparam int CODE_W     = 8;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef logic [CODE_W-1:0]    code_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes
	localparam cfg_idx_t CFG_IMAGE_WIDTH   = 2'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 2'd1;
	localparam cfg_idx_t CFG_INTERIOR_CODE = 2'd2;
	localparam cfg_idx_t CFG_CORE_CODE     = 2'd3;

	// register reset values
	localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
	localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT  = 16'd1024;
	localparam code_t              RST_INTERIOR_CODE = 8'd2;
	localparam code_t              RST_CORE_CODE     = 8'd1;

	// which neighbors of the emitted pixel lie inside the frame, and whether it is the frame's last pixel
	typedef struct packed {
		logic left_ok;
		logic right_ok;
		logic up_ok;
		logic dn_ok;
		logic last;
	} nbr_t;

endpackage

// ===== hdl/cbd_if.sv =====
// ----------------------------------------------------------------------------
// cbd_if: stream channels of the class border dilation block
// Pixel channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbd_pix_if
	import cbd_pkg::*;
	();

	logic  valid;
	logic  ready;
	code_t pixel_class;
	logic  flush;

	modport source (output valid, output pixel_class, output flush, input ready);
	modport sink (input valid, input pixel_class, input flush, output ready);

endinterface

interface cbd_res_if
	import cbd_pkg::*;
	();

	logic  valid;
	logic  ready;
	code_t out_class;
	logic  frame_last;

	modport source (output valid, output out_class, output frame_last, input ready);
	modport sink (input valid, input out_class, input frame_last, output ready);

endinterface

// ===== hdl/cbd_linebuf.sv =====
// ----------------------------------------------------------------------------
// cbd_linebuf: two row delay lines for the 3x3 window
// The middle row memory delays the incoming code by one row, the upper row
// memory delays that by one more row. Reads are registered; a write to the
// upper row that lands on the address being read is forwarded.
// ----------------------------------------------------------------------------
module cbd_linebuf
	import cbd_pkg::*;
	#(
		parameter int  MAX_WIDTH = CBD_MAX_WIDTH,
		localparam int AW        = $clog2(MAX_WIDTH)
	)
	(
		input  logic          clk,
		input  logic          shift,
		input  logic [AW-1:0] addr,
		input  code_t         din,
		input  logic          commit,
		output code_t         mid,
		output code_t         up
	);

	code_t         mem_mid [MAX_WIDTH];
	code_t         mem_up  [MAX_WIDTH];
	code_t         mid_s1;
	code_t         up_rd_s1;
	code_t         byp_data_s1;
	logic          byp_s1;
	logic [AW-1:0] addr_s1;

	// middle row: read the code one row back, store the new one
	always_ff @(posedge clk) begin
		if (shift) begin
			mid_s1        <= mem_mid[addr];
			mem_mid[addr] <= din;
		end
	end

	// upper row: move the middle row read into it when the item leaves
	always_ff @(posedge clk) begin
		if (commit) begin
			mem_up[addr_s1] <= mid_s1;
		end
		if (shift) begin
			up_rd_s1 <= mem_up[addr];
		end
	end

	// forward an upper row write that hits the address read at the same edge
	always_ff @(posedge clk) begin
		if (shift) begin
			addr_s1     <= addr;
			byp_s1      <= commit && (addr == addr_s1);
			byp_data_s1 <= mid_s1;
		end
	end

	assign mid = mid_s1;
	assign up  = byp_s1 ? byp_data_s1 : up_rd_s1;

endmodule

// ===== hdl/cbd_win.sv =====
// ----------------------------------------------------------------------------
// cbd_win: 3x3 window and border rewrite decision
// Holds the left and center columns of the window; the right column comes
// straight from the line buffer stage. Rewrites the center to the interior
// code when it is neither interior nor core and an in-frame neighbor is
// interior.
// ----------------------------------------------------------------------------
module cbd_win
	import cbd_pkg::*;
	(
		input  logic  clk,
		input  logic  step,
		input  code_t up_r,
		input  code_t mid_r,
		input  code_t lo_r,
		input  nbr_t  nbr,
		input  code_t interior,
		input  code_t core,
		output code_t result
	);

	code_t up_l_q, up_c_q;
	code_t mid_l_q, mid_c_q;
	code_t lo_l_q, lo_c_q;
	logic  hit_up, hit_mid, hit_lo;

	// advance the window by one column
	always_ff @(posedge clk) begin
		if (step) begin
			up_l_q  <= up_c_q;
			up_c_q  <= up_r;
			mid_l_q <= mid_c_q;
			mid_c_q <= mid_r;
			lo_l_q  <= lo_c_q;
			lo_c_q  <= lo_r;
		end
	end

	// look for an interior neighbor inside the frame
	always_comb begin
		hit_up  = nbr.up_ok && ((nbr.left_ok && (up_l_q == interior))
			|| (up_c_q == interior) || (nbr.right_ok && (up_r == interior)));
		hit_mid = (nbr.left_ok && (mid_l_q == interior))
			|| (nbr.right_ok && (mid_r == interior));
		hit_lo  = nbr.dn_ok && ((nbr.left_ok && (lo_l_q == interior))
			|| (lo_c_q == interior) || (nbr.right_ok && (lo_r == interior)));
	end

	// rewrite border cells, pass everything else
	assign result = ((mid_c_q != interior) && (mid_c_q != core)
		&& (hit_up || hit_mid || hit_lo)) ? interior : mid_c_q;

endmodule

// ===== hdl/class_border_dilation_3x3_core.sv =====
// ----------------------------------------------------------------------------
// class_border_dilation_3x3_core: conditional 3x3 dilation of a class raster
// Pipeline: an item that releases a result passes the line buffer read stage,
//   then the result register.
// Throughput: one item per cycle while the output is not stalled, set by one
//   read and one write per cycle on each row memory; after the last pixel of a
//   one-row frame the input is held while the window steps once without an item.
// Reset: registers take their reset values, counters and valids clear; the
//   row memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module class_border_dilation_3x3_core
	import cbd_pkg::*;
	#(
		parameter int MAX_WIDTH = CBD_MAX_WIDTH
	)
	(
		input  logic                  clk,
		input  logic                  arst_n,
		input  logic                  cfg_we,
		input  cfg_idx_t              cfg_idx,
		input  logic [CFG_DATA_W-1:0] cfg_wdata,
		cbd_pix_if.sink               pix,
		cbd_res_if.source             res
	);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 3);

	// configuration
	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	code_t              interior_q;
	code_t              core_q;

	logic [31:0]        wreq;
	logic [WW-1:0]      w_eff;
	logic [WW-1:0]      w_m1;
	logic [AW-1:0]      w_last;
	logic [IMG_H_W-1:0] h_last;
	logic               cfg_geo;

	// frame position and drain control
	logic [AW-1:0]      col_q, col_n;
	logic [IMG_H_W-1:0] row_q, row_n;
	logic [PW-1:0]      pend_q, pend_n;
	logic [AW-1:0]      ocol_q, ocol_n;
	logic [IMG_H_W-1:0] orow_q, orow_n;
	logic               drain_q, drain_n;
	logic               pad_q, pad_n;

	logic               adv;
	logic               in_ready;
	logic               acc;
	logic               shift;
	logic               emit;
	logic               restart;
	nbr_t               nbr;

	// line buffer stage
	logic               s1_valid;
	logic               s1_emit;
	nbr_t               s1_nbr;
	code_t              lo_s1;
	code_t              mid_rd;
	code_t              up_rd;
	code_t              result;

	// result register
	logic               out_valid_q;
	code_t              out_class_q;
	logic               last_q;

	// clamp the geometry
	assign wreq = 32'(width_q);

	always_comb begin
		if (wreq == 32'd0) begin
			w_eff = WW'(1);
		end else if (wreq > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(wreq);
		end
	end

	assign w_m1   = w_eff - WW'(1);
	assign w_last = w_m1[AW-1:0];
	assign h_last = (height_q == '0) ? '0 : height_q - IMG_H_W'(1);

	assign cfg_geo = cfg_we && ((cfg_idx == CFG_IMAGE_WIDTH) || (cfg_idx == CFG_IMAGE_HEIGHT));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_IMAGE_WIDTH;
			height_q   <= RST_IMAGE_HEIGHT;
			interior_q <= RST_INTERIOR_CODE;
			core_q     <= RST_CORE_CODE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IMAGE_WIDTH:   width_q    <= cfg_wdata[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT:  height_q   <= cfg_wdata[IMG_H_W-1:0];
				CFG_INTERIOR_CODE: interior_q <= cfg_wdata[CODE_W-1:0];
				CFG_CORE_CODE:     core_q     <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv      = !out_valid_q || res.ready;
	assign in_ready = adv && !pad_q;
	assign acc      = pix.valid && in_ready;

	// neighbors of the pixel that would be emitted now
	always_comb begin
		nbr.left_ok  = (ocol_q != '0);
		nbr.right_ok = (ocol_q != w_last);
		nbr.up_ok    = (orow_q != '0);
		nbr.dn_ok    = (orow_q != h_last);
		nbr.last     = (ocol_q == w_last) && (orow_q == h_last);
	end

	// step the frame position, pending count and drain state
	always_comb begin
		shift   = 1'b0;
		emit    = 1'b0;
		restart = 1'b0;
		col_n   = col_q;
		row_n   = row_q;
		pend_n  = pend_q;
		ocol_n  = ocol_q;
		orow_n  = orow_q;
		drain_n = drain_q;
		pad_n   = pad_q;

		if (pad_q) begin
			// extra window step after a one-row frame
			if (adv) begin
				shift = 1'b1;
				pad_n = 1'b0;
			end
		end else if (acc) begin
			if (drain_q) begin
				if (pend_q == '0) begin
					restart = 1'b1;
				end else begin
					shift  = 1'b1;
					emit   = 1'b1;
					pend_n = pend_q - PW'(1);
					if (pend_q == PW'(1)) begin
						restart = 1'b1;
					end
				end
			end else if (!pix.flush) begin
				shift = 1'b1;
				if (col_q == w_last) begin
					if (row_q == h_last) begin
						row_n   = '0;
						drain_n = 1'b1;
						pad_n   = (h_last == '0);
					end else begin
						row_n = row_q + IMG_H_W'(1);
					end
				end
				if (pend_q > PW'(w_eff)) begin
					emit = 1'b1;
				end else begin
					pend_n = pend_q + PW'(1);
				end
			end
		end

		if (shift) begin
			col_n = (col_q == w_last) ? '0 : col_q + AW'(1);
		end

		if (emit) begin
			if (ocol_q == w_last) begin
				ocol_n = '0;
				orow_n = orow_q + IMG_H_W'(1);
			end else begin
				ocol_n = ocol_q + AW'(1);
			end
		end

		if (restart || cfg_geo) begin
			col_n   = '0;
			row_n   = '0;
			pend_n  = '0;
			ocol_n  = '0;
			orow_n  = '0;
			drain_n = 1'b0;
			pad_n   = 1'b0;
		end
	end

	// control state and line buffer stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			pend_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			drain_q  <= 1'b0;
			pad_q    <= 1'b0;
			s1_valid <= 1'b0;
			s1_emit  <= 1'b0;
			s1_nbr   <= '0;
		end else begin
			col_q   <= col_n;
			row_q   <= row_n;
			pend_q  <= pend_n;
			ocol_q  <= ocol_n;
			orow_q  <= orow_n;
			drain_q <= drain_n;
			pad_q   <= pad_n;
			if (adv) begin
				s1_valid <= shift;
				s1_emit  <= emit;
				s1_nbr   <= nbr;
			end
		end
	end

	// hold the newest code for the lower row of the window
	always_ff @(posedge clk) begin
		if (shift) begin
			lo_s1 <= pix.pixel_class;
		end
	end

	cbd_linebuf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_linebuf (
		.clk    (clk),
		.shift  (shift),
		.addr   (col_q),
		.din    (pix.pixel_class),
		.commit (adv && s1_valid),
		.mid    (mid_rd),
		.up     (up_rd)
	);

	cbd_win u_win (
		.clk      (clk),
		.step     (adv && s1_valid),
		.up_r     (up_rd),
		.mid_r    (mid_rd),
		.lo_r     (lo_s1),
		.nbr      (s1_nbr),
		.interior (interior_q),
		.core     (core_q),
		.result   (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid && s1_emit) begin
			out_class_q <= result;
			last_q      <= s1_nbr.last;
		end
	end

	assign pix.ready      = in_ready;
	assign res.valid      = out_valid_q;
	assign res.out_class  = out_class_q;
	assign res.frame_last = last_q;

	// pending pixels never exceed one row plus one
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(w_eff) + PW'(1))
		else $error("pending count beyond one row plus one pixel");

	// the extra window step only follows the end of a frame
	a_pad_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> drain_q)
		else $error("window pad step outside of drain");

	// a new result always comes from an emitting item in the read stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid && s1_emit))
		else $error("result appeared without an emitting item");

endmodule
